### sv/mrrd_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mrrd_pkg
// Shared types, codes and the CRC-16 byte update for the request detector.
// ----------------------------------------------------------------------------
package mrrd_pkg;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned StatusW = 2;
  localparam int unsigned PosW    = 3;
  localparam int unsigned CrcW    = 16;
  localparam int unsigned TickW   = 16;

  localparam logic [CrcW-1:0] CrcInit = 16'hFFFF;
  localparam logic [CrcW-1:0] CrcPoly = 16'hA001;

  localparam logic [TickW-1:0] TimeoutReset = 16'd10;

  localparam logic [ByteW-1:0] FuncLow  = 8'd1;
  localparam logic [ByteW-1:0] FuncHigh = 8'd6;

  // item kinds
  localparam logic OpByte = 1'b0;
  localparam logic OpTick = 1'b1;

  // result codes
  localparam logic [StatusW-1:0] StValid   = 2'd0;
  localparam logic [StatusW-1:0] StCrcErr  = 2'd1;
  localparam logic [StatusW-1:0] StUnsupp  = 2'd2;
  localparam logic [StatusW-1:0] StTimeout = 2'd3;

  // frame positions
  localparam logic [PosW-1:0] PosIdle  = 3'd0;
  localparam logic [PosW-1:0] PosFunc  = 3'd1;
  localparam logic [PosW-1:0] PosData0 = 3'd2;
  localparam logic [PosW-1:0] PosData1 = 3'd3;
  localparam logic [PosW-1:0] PosData2 = 3'd4;
  localparam logic [PosW-1:0] PosData3 = 3'd5;
  localparam logic [PosW-1:0] PosCrcLo = 3'd6;
  localparam logic [PosW-1:0] PosCrcHi = 3'd7;

  typedef struct packed {
    logic             op;
    logic [ByteW-1:0] value;
  } item_t;

  typedef struct packed {
    logic [StatusW-1:0] status;
    logic [ByteW-1:0]   addr;
    logic [ByteW-1:0]   func;
    logic [4*ByteW-1:0] data;
  } result_t;

  function automatic logic [CrcW-1:0] crc16_byte(input logic [CrcW-1:0] crc,
                                                 input logic [ByteW-1:0] b);
    logic [CrcW-1:0] c;
    c = crc ^ {{(CrcW-ByteW){1'b0}}, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
    end
    return c;
  endfunction

endpackage
`default_nettype wire

### sv/mrrd_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mrrd_queue
// Front side: accepts input words, each tagged by kind, and buffers them for the
// frame parser.
// ----------------------------------------------------------------------------
module mrrd_queue #(
  parameter int unsigned DEPTH = 2
) (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  push_i,
  output logic                 full_o,
  input  mrrd_pkg::item_t      item_i,
  output logic                 valid_o,
  input  wire                  pop_i,
  output mrrd_pkg::item_t      item_o
);
  import mrrd_pkg::*;

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(DEPTH);

  item_t           mem_q [DEPTH];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == FullCnt);
  assign valid_o = (cnt_q != '0);
  assign item_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= FullCnt)
    else $error("queue count beyond depth");

  a_pop_drains: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == CntW'(1) && do_pop && !do_push) |=> !valid_o)
    else $error("queue not empty after last word popped");

endmodule
`default_nettype wire

### sv/mrrd_parser.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mrrd_parser
// Back side: walks the frame, updates the CRC, counts ticks and registers one
// result per finished frame.
// ----------------------------------------------------------------------------
module mrrd_parser (
  input  wire                      clk_i,
  input  wire                      rst_ni,
  input  wire [15:0]               timeout_i,
  input  wire                      q_valid_i,
  input  mrrd_pkg::item_t          q_item_i,
  output logic                     q_pop_o,
  output logic                     res_valid_o,
  input  wire                      res_ready_i,
  output mrrd_pkg::result_t        res_o
);
  import mrrd_pkg::*;

  logic [PosW-1:0]    pos_q, pos_d;
  logic [TickW-1:0]   ticks_q, ticks_d, ticks_inc;
  logic [ByteW-1:0]   addr_q, addr_d;
  logic [ByteW-1:0]   func_q, func_d;
  logic [4*ByteW-1:0] data_q, data_d;
  logic [CrcW-1:0]    crc_q, crc_d, crc_upd;
  logic [ByteW-1:0]   crc_lo_q, crc_lo_d;
  logic               out_valid_q, out_valid_d;
  result_t            res_q, res_d;
  logic               step, emit;
  logic [StatusW-1:0] emit_status;
  logic [ByteW-1:0]   b;

  assign b         = q_item_i.value;
  assign step      = q_valid_i && (!out_valid_q || res_ready_i);
  assign q_pop_o   = step;
  assign crc_upd   = crc16_byte((pos_q == PosIdle) ? CrcInit : crc_q, b);
  assign ticks_inc = (ticks_q == '1) ? ticks_q : ticks_q + TickW'(1);

  always_comb begin
    pos_d       = pos_q;
    ticks_d     = ticks_q;
    addr_d      = addr_q;
    func_d      = func_q;
    data_d      = data_q;
    crc_d       = crc_q;
    crc_lo_d    = crc_lo_q;
    emit        = 1'b0;
    emit_status = StValid;
    if (step) begin
      if (q_item_i.op == OpTick) begin
        if (pos_q != PosIdle) begin
          if (ticks_inc > timeout_i) begin
            emit        = 1'b1;
            emit_status = StTimeout;
            pos_d       = PosIdle;
            ticks_d     = '0;
          end else begin
            ticks_d = ticks_inc;
          end
        end
      end else begin
        ticks_d = '0;
        unique case (pos_q)
          PosIdle: begin
            addr_d   = b;
            func_d   = '0;
            data_d   = '0;
            crc_lo_d = '0;
            crc_d    = crc_upd;
            pos_d    = PosFunc;
          end
          PosFunc: begin
            func_d = b;
            if (b >= FuncLow && b <= FuncHigh) begin
              crc_d = crc_upd;
              pos_d = PosData0;
            end else begin
              emit        = 1'b1;
              emit_status = StUnsupp;
              pos_d       = PosIdle;
            end
          end
          PosData0: begin
            data_d[7:0] = b;
            crc_d       = crc_upd;
            pos_d       = PosData1;
          end
          PosData1: begin
            data_d[15:8] = b;
            crc_d        = crc_upd;
            pos_d        = PosData2;
          end
          PosData2: begin
            data_d[23:16] = b;
            crc_d         = crc_upd;
            pos_d         = PosData3;
          end
          PosData3: begin
            data_d[31:24] = b;
            crc_d         = crc_upd;
            pos_d         = PosCrcLo;
          end
          PosCrcLo: begin
            crc_lo_d = b;
            pos_d    = PosCrcHi;
          end
          PosCrcHi: begin
            emit        = 1'b1;
            emit_status = ({b, crc_lo_q} == crc_q) ? StValid : StCrcErr;
            pos_d       = PosIdle;
          end
          default: begin
            pos_d = PosIdle;
          end
        endcase
      end
    end
  end

  always_comb begin
    out_valid_d = out_valid_q && !res_ready_i;
    res_d       = res_q;
    if (emit) begin
      out_valid_d  = 1'b1;
      res_d.status = emit_status;
      res_d.addr   = addr_d;
      res_d.func   = func_d;
      res_d.data   = (emit_status == StValid) ? data_d : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= PosIdle;
      ticks_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      pos_q       <= pos_d;
      ticks_q     <= ticks_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    addr_q   <= addr_d;
    func_q   <= func_d;
    data_q   <= data_d;
    crc_q    <= crc_d;
    crc_lo_q <= crc_lo_d;
    res_q    <= res_d;
  end

  assign res_valid_o = out_valid_q;
  assign res_o       = res_q;

  a_idle_no_ticks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pos_q == PosIdle) |-> (ticks_q == '0))
    else $error("tick count nonzero while idle");

  a_data_only_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && res_q.status != StValid) |-> (res_q.data == '0))
    else $error("data bytes on a failed frame");

  a_emit_slot_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !res_ready_i) |-> !q_pop_o)
    else $error("word consumed while result stalled");

endmodule
`default_nettype wire

### sv/modbus_rtu_request_detector.sv
`default_nettype none
// ----------------------------------------------------------------------------
// modbus_rtu_request_detector
// Modbus RTU request detector with CRC-16 check and inter-byte timeout.
// ----------------------------------------------------------------------------
// Takes one word per clock (a received byte or a time tick) while the queue
// has room and gives one result per frame: valid request, CRC mismatch,
// unsupported function (any code outside 1 to 6) or timeout. Words enter a
// small queue and the frame parser drains it at one word per cycle while no
// result waits; a result is held in an output register until taken.
// Sustained rate is one word per cycle, set by the combinational CRC byte
// update in the parser; m_axis_tready low stalls the parser once a result
// waits, and the input stalls when the queue (QUEUE_DEPTH words) is full.
module modbus_rtu_request_detector #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  input  wire  [7:0]  s_axis_tdata,   // [7:0] byte_value
  input  wire  [0:0]  s_axis_tuser,   // [0] op
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  output logic [47:0] m_axis_tdata,   // [7:0] slave_address, [15:8] function_code,
                                      // [23:16] data_byte_0, [31:24] data_byte_1,
                                      // [39:32] data_byte_2, [47:40] data_byte_3
  output logic [1:0]  m_axis_tuser,   // [1:0] status
  input  wire         cfg_valid_i,
  output logic        cfg_ready_o,
  input  wire  [15:0] cfg_data_i      // [15:0] timeout_ticks
);
  import mrrd_pkg::*;

  logic [TickW-1:0] timeout_q;
  item_t            in_item, q_item;
  logic             q_full, q_valid, q_pop;
  logic             res_valid;
  result_t          res;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q <= TimeoutReset;
    end else if (cfg_valid_i) begin
      timeout_q <= cfg_data_i;
    end
  end

  assign in_item.op    = s_axis_tuser[0];
  assign in_item.value = s_axis_tdata;
  assign s_axis_tready = !q_full;

  mrrd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (s_axis_tvalid),
    .full_o  (q_full),
    .item_i  (in_item),
    .valid_o (q_valid),
    .pop_i   (q_pop),
    .item_o  (q_item)
  );

  mrrd_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .timeout_i   (timeout_q),
    .q_valid_i   (q_valid),
    .q_item_i    (q_item),
    .q_pop_o     (q_pop),
    .res_valid_o (res_valid),
    .res_ready_i (m_axis_tready),
    .res_o       (res)
  );

  assign m_axis_tvalid = res_valid;
  assign m_axis_tuser  = res.status;
  assign m_axis_tdata  = {res.data, res.func, res.addr};

endmodule
`default_nettype wire

### verif/modbus_rtu_request_detector_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// modbus_rtu_request_detector_tb
// Self-checking testbench for the Modbus RTU request detector.
// ----------------------------------------------------------------------------
// Drives byte and tick words into the input stream and tracks the frame
// parser state alongside the block: address, function, four data bytes and a
// CRC-16 over the first six bytes. Every frame outcome (valid request, CRC
// mismatch, unsupported function, inter-byte timeout) is queued as it is
// predicted and compared field by field with the result stream. Directed
// tests cover edge values, all supported and several unsupported function codes,
// the zero and full timeout settings and a long tick gap; random traffic
// follows under several timeout settings and stall patterns on both streams.
// ----------------------------------------------------------------------------
module modbus_rtu_request_detector_tb;
  import mrrd_pkg::*;

  localparam int unsigned StallLimit   = 4000;
  localparam int unsigned SettleCycles = 12;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata  = '0;
  logic [0:0]  s_axis_tuser  = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [47:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;
  logic        cfg_valid_i   = 1'b0;
  logic        cfg_ready_o;
  logic [15:0] cfg_data_i    = '0;

  int unsigned src_idle_pct = 0;
  int unsigned snk_idle_pct = 0;
  int unsigned errors       = 0;
  int unsigned words_sent   = 0;
  int unsigned stall_count  = 0;

  // parser state tracked alongside the block
  logic [TickW-1:0]   timeout_limit = TimeoutReset;
  logic [PosW-1:0]    frame_pos     = PosIdle;
  logic [ByteW-1:0]   frame_addr    = '0;
  logic [ByteW-1:0]   frame_func    = '0;
  logic [4*ByteW-1:0] frame_data    = '0;
  logic [CrcW-1:0]    frame_crc     = CrcInit;
  logic [ByteW-1:0]   crc_lo        = '0;
  logic [TickW-1:0]   tick_count    = '0;

  result_t pending[$];
  result_t head_r;

  modbus_rtu_request_detector dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  function automatic logic [CrcW-1:0] crc_step(input logic [CrcW-1:0] crc,
                                               input logic [ByteW-1:0] b);
    logic [CrcW-1:0] c;
    c = crc;
    for (int i = 0; i < ByteW; i++) begin
      if (c[0] ^ b[i]) c = (c >> 1) ^ CrcPoly;
      else c = c >> 1;
    end
    return c;
  endfunction

  task automatic track_word(input logic op, input logic [ByteW-1:0] val);
    result_t r;
    bit      hit;
    int      idx;
    r   = '0;
    hit = 1'b0;
    if (op == OpTick) begin
      if (frame_pos != PosIdle) begin
        if (tick_count != '1) tick_count++;
        if (tick_count > timeout_limit) begin
          r.status = StTimeout;
          hit      = 1'b1;
        end
      end
    end else begin
      tick_count = '0;
      case (frame_pos)
        PosIdle: begin
          frame_addr = val;
          frame_func = '0;
          frame_data = '0;
          crc_lo     = '0;
          frame_crc  = crc_step(CrcInit, val);
          frame_pos  = PosFunc;
        end
        PosFunc: begin
          frame_func = val;
          if (val >= FuncLow && val <= FuncHigh) begin
            frame_crc = crc_step(frame_crc, val);
            frame_pos = PosData0;
          end else begin
            r.status = StUnsupp;
            hit      = 1'b1;
          end
        end
        PosData0, PosData1, PosData2, PosData3: begin
          idx = int'(frame_pos - PosData0);
          frame_data[8*idx +: 8] = val;
          frame_crc = crc_step(frame_crc, val);
          frame_pos = frame_pos + 1'b1;
        end
        PosCrcLo: begin
          crc_lo    = val;
          frame_pos = PosCrcHi;
        end
        default: begin
          if ({val, crc_lo} == frame_crc) begin
            r.status = StValid;
            r.data   = frame_data;
          end else begin
            r.status = StCrcErr;
          end
          hit = 1'b1;
        end
      endcase
    end
    if (hit) begin
      r.addr = frame_addr;
      r.func = frame_func;
      pending.push_back(r);
      frame_pos  = PosIdle;
      tick_count = '0;
    end
  endtask

  task automatic send_word(input logic op, input logic [ByteW-1:0] val);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= val;
    s_axis_tuser  <= op;
    do @(posedge clk_i); while (!s_axis_tready);
    if (!(op == OpTick && frame_pos == PosIdle)) words_sent++;
    track_word(op, val);
  endtask

  task automatic send_ticks(input int unsigned n);
    repeat (n) send_word(OpTick, 8'($urandom));
  endtask

  // send the first nbytes bytes of a frame, CRC xor-ed with crc_flip
  task automatic send_frame(input logic [7:0] addr, input logic [7:0] func,
                            input logic [31:0] data, input logic [15:0] crc_flip,
                            input int nbytes, input int unsigned gap);
    logic [7:0]  bytes [8];
    logic [15:0] crc;
    bytes[0] = addr;
    bytes[1] = func;
    for (int j = 0; j < 4; j++) bytes[2+j] = data[8*j +: 8];
    crc = CrcInit;
    for (int j = 0; j < 6; j++) crc = crc_step(crc, bytes[j]);
    crc = crc ^ crc_flip;
    bytes[6] = crc[7:0];
    bytes[7] = crc[15:8];
    for (int j = 0; j < nbytes; j++) begin
      if (j > 0) send_ticks($urandom_range(gap));
      send_word(OpByte, bytes[j]);
    end
  endtask

  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (pending.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_timeout(input logic [15:0] v);
    settle();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    timeout_limit = v;
  endtask

  task automatic check_field(input string name, input int unsigned exp_v,
                             input int unsigned act_v);
    if (exp_v != act_v) begin
      $error("%s mismatch: expected %0h, got %0h", name, exp_v, act_v);
      errors++;
    end
  endtask

  task automatic test_basic_frames();
    send_ticks(3);
    send_frame(8'h00, 8'h01, 32'h0000_0000, 16'h0000, 8, 2);
    send_frame(8'hFF, 8'h06, 32'hFFFF_FFFF, 16'h0000, 8, 10);
    send_frame(8'h11, 8'h03, 32'h0300_6B00, 16'h0000, 8, 0);
    send_frame(8'hA5, 8'h04, 32'h1234_5678, 16'h8001, 8, 1);
    send_frame(8'h5A, 8'h02, 32'h0, 16'h0, 1, 0);
    send_ticks(11);
    send_frame(8'h3C, 8'h05, 32'h0, 16'h0, 4, 0);
    send_ticks(11);
  endtask

  task automatic test_function_codes();
    for (int f = 1; f <= 6; f++)
      send_frame(8'($urandom), 8'(f), $urandom, 16'h0000, 8, 1);
    send_frame(8'h01, 8'h00, 32'h0, 16'h0, 2, 0);
    send_frame(8'h02, 8'h07, 32'h0, 16'h0, 2, 0);
    send_frame(8'h03, 8'h0F, 32'h0, 16'h0, 2, 0);
    send_frame(8'h04, 8'h10, 32'h0, 16'h0, 2, 0);
    send_frame(8'h05, 8'hFF, 32'h0, 16'h0, 2, 0);
  endtask

  task automatic test_timeout_limits();
    write_timeout(16'd0);
    send_frame(8'h21, 8'h03, 32'h0, 16'h0, 1, 0);
    send_ticks(1);
    write_timeout(16'd1);
    send_frame(8'h22, 8'h03, 32'hCAFE_F00D, 16'h0, 8, 1);
    send_frame(8'h23, 8'h03, 32'h0, 16'h0, 3, 1);
    send_ticks(2);
  endtask

  task automatic test_full_timeout();
    logic [7:0]  fr [6];
    logic [15:0] crc;
    write_timeout(16'hFFFF);
    fr = '{8'h7E, 8'h03, 8'h00, 8'h10, 8'hFF, 8'h01};
    crc = CrcInit;
    for (int j = 0; j < 6; j++) crc = crc_step(crc, fr[j]);
    send_word(OpByte, fr[0]);
    send_word(OpByte, fr[1]);
    send_ticks(100);
    for (int j = 2; j < 6; j++) send_word(OpByte, fr[j]);
    send_word(OpByte, crc[7:0]);
    send_word(OpByte, crc[15:8]);
  endtask

  task automatic test_random_traffic(input int unsigned n, input logic [15:0] tmo);
    int unsigned kind;
    int unsigned gap;
    int unsigned target;
    logic [7:0]  func;
    write_timeout(tmo);
    gap    = (tmo < 3) ? tmo : 3;
    target = words_sent + n;
    while (words_sent < target) begin
      kind = $urandom_range(99);
      func = 8'($urandom_range(FuncHigh, FuncLow));
      if (kind < 60) begin
        send_frame(8'($urandom), func, $urandom, 16'h0000, 8, gap);
      end else if (kind < 70) begin
        send_frame(8'($urandom), func, $urandom, 16'($urandom_range(16'hFFFF, 1)),
                   8, gap);
      end else if (kind < 78) begin
        do func = 8'($urandom); while (func >= FuncLow && func <= FuncHigh);
        send_frame(8'($urandom), func, 32'h0, 16'h0, 2, gap);
      end else if (kind < 88 && tmo <= 64) begin
        send_frame(8'($urandom), func, $urandom, 16'h0, $urandom_range(7, 1), gap);
        send_ticks(tmo + 1);
      end else if (kind < 88) begin
        send_frame(8'($urandom), func, $urandom, 16'h0000, 8, gap);
      end else begin
        repeat ($urandom_range(4, 1)) send_word(1'($urandom), 8'($urandom));
      end
    end
  endtask

  always @(posedge clk_i) m_axis_tready <= ($urandom_range(99) >= snk_idle_pct);

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending.size() == 0) begin
        $error("unexpected result word: status %0h data %0h", m_axis_tuser, m_axis_tdata);
        errors++;
      end else begin
        head_r = pending.pop_front();
        check_field("status", head_r.status, m_axis_tuser);
        check_field("slave_address", head_r.addr, m_axis_tdata[7:0]);
        check_field("function_code", head_r.func, m_axis_tdata[15:8]);
        for (int j = 0; j < 4; j++)
          check_field($sformatf("data_byte_%0d", j), head_r.data[8*j +: 8],
                      m_axis_tdata[16+8*j +: 8]);
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) begin
      stall_count <= 0;
    end else if (stall_count >= StallLimit) begin
      $display("FAIL");
      $finish;
    end else begin
      stall_count <= stall_count + 1;
    end
  end

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    src_idle_pct = 26;
    snk_idle_pct = 61;
    test_basic_frames();
    test_function_codes();
    test_timeout_limits();
    test_full_timeout();
    test_random_traffic(110, TimeoutReset);
    test_random_traffic(100, 16'd65535);
    src_idle_pct = 61;
    snk_idle_pct = 26;
    test_random_traffic(100, 16'd1);
    src_idle_pct = 0;
    snk_idle_pct = 0;
    test_random_traffic(90, 16'($urandom_range(40, 2)));
    settle();
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
